// ----- sv/ppm_pkg.sv -----
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared types, constants and palette tables of the palette mapper.
// ----------------------------------------------------------------------------
package ppm_pkg;

  localparam int TableSize  = 256;
  localparam int MaxStops   = 16;
  localparam int LevelW     = 8;
  localparam int ChanW      = 8;
  localparam int StopIdxW   = 4;
  localparam int GainW      = 12;
  localparam int ShiftW     = 9;
  localparam int PalW       = 3;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 12;

  localparam logic [CfgIdxW-1:0] REG_PALETTE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SHIFT   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN    = 2'd2;

  localparam logic [PalW-1:0] PAL_JET      = 3'd0;
  localparam logic [PalW-1:0] PAL_RAINBOW  = 3'd1;
  localparam logic [PalW-1:0] PAL_COOLWARM = 3'd2;
  localparam logic [PalW-1:0] PAL_INFERNO  = 3'd3;
  localparam logic [PalW-1:0] PAL_KINDL    = 3'd4;
  localparam logic [PalW-1:0] PAL_KINDL_X  = 3'd5;

  typedef logic [3*ChanW-1:0] rgb_t;

  typedef struct packed {
    logic              en;
    logic [LevelW-1:0] addr;
    rgb_t              rgb;
  } ppm_wr_t;

  function automatic logic [4:0] stop_count(input logic [PalW-1:0] pal);
    logic [4:0] r;
    case (pal)
      PAL_JET:      r = 5'd6;
      PAL_RAINBOW:  r = 5'd5;
      PAL_COOLWARM: r = 5'd3;
      PAL_INFERNO:  r = 5'd8;
      PAL_KINDL:    r = 5'd12;
      PAL_KINDL_X:  r = 5'd16;
      default:      r = 5'd0;
    endcase
    return r;
  endfunction

  // unshifted stop position k*TableSize/(R-1)-1, stop 0 at 0
  function automatic logic [LevelW-1:0] base_pos(input logic [PalW-1:0] pal,
                                                 input logic [StopIdxW-1:0] k);
    logic [LevelW-1:0] p;
    p = '0;
    case (pal)
      PAL_JET: begin
        case (k)
          4'd1: p = 8'd50;  4'd2: p = 8'd101; 4'd3: p = 8'd152;
          4'd4: p = 8'd203; 4'd5: p = 8'd255; default: p = '0;
        endcase
      end
      PAL_RAINBOW: begin
        case (k)
          4'd1: p = 8'd63;  4'd2: p = 8'd127; 4'd3: p = 8'd191;
          4'd4: p = 8'd255; default: p = '0;
        endcase
      end
      PAL_COOLWARM: begin
        case (k)
          4'd1: p = 8'd127; 4'd2: p = 8'd255; default: p = '0;
        endcase
      end
      PAL_INFERNO: begin
        case (k)
          4'd1: p = 8'd35;  4'd2: p = 8'd72;  4'd3: p = 8'd108;
          4'd4: p = 8'd145; 4'd5: p = 8'd181; 4'd6: p = 8'd218;
          4'd7: p = 8'd255; default: p = '0;
        endcase
      end
      PAL_KINDL: begin
        case (k)
          4'd1: p = 8'd22;  4'd2: p = 8'd45;  4'd3: p = 8'd68;
          4'd4: p = 8'd92;  4'd5: p = 8'd115; 4'd6: p = 8'd138;
          4'd7: p = 8'd161; 4'd8: p = 8'd185; 4'd9: p = 8'd208;
          4'd10: p = 8'd231; 4'd11: p = 8'd255; default: p = '0;
        endcase
      end
      PAL_KINDL_X: begin
        case (k)
          4'd1: p = 8'd16;  4'd2: p = 8'd33;  4'd3: p = 8'd50;
          4'd4: p = 8'd67;  4'd5: p = 8'd84;  4'd6: p = 8'd101;
          4'd7: p = 8'd118; 4'd8: p = 8'd135; 4'd9: p = 8'd152;
          4'd10: p = 8'd169; 4'd11: p = 8'd186; 4'd12: p = 8'd203;
          4'd13: p = 8'd220; 4'd14: p = 8'd237; 4'd15: p = 8'd255;
          default: p = '0;
        endcase
      end
      default: p = '0;
    endcase
    return p;
  endfunction

  // stop colour packed {blue, green, red}
  function automatic rgb_t stop_color(input logic [PalW-1:0] pal,
                                      input logic [StopIdxW-1:0] k);
    rgb_t c;
    c = '0;
    case (pal)
      PAL_JET: begin
        case (k)
          4'd0: c = {8'd153, 8'd0,   8'd0};
          4'd1: c = {8'd255, 8'd0,   8'd0};
          4'd2: c = {8'd255, 8'd255, 8'd0};
          4'd3: c = {8'd0,   8'd255, 8'd255};
          4'd4: c = {8'd0,   8'd0,   8'd255};
          4'd5: c = {8'd0,   8'd0,   8'd153};
          default: c = '0;
        endcase
      end
      PAL_RAINBOW: begin
        case (k)
          4'd0: c = {8'd255, 8'd0,   8'd0};
          4'd1: c = {8'd255, 8'd255, 8'd0};
          4'd2: c = {8'd0,   8'd255, 8'd0};
          4'd3: c = {8'd0,   8'd255, 8'd255};
          4'd4: c = {8'd0,   8'd0,   8'd255};
          default: c = '0;
        endcase
      end
      PAL_COOLWARM: begin
        case (k)
          4'd0: c = {8'd192, 8'd76,  8'd59};
          4'd1: c = {8'd221, 8'd221, 8'd221};
          4'd2: c = {8'd38,  8'd4,   8'd180};
          default: c = '0;
        endcase
      end
      PAL_INFERNO: begin
        case (k)
          4'd0: c = {8'd4,   8'd0,   8'd0};
          4'd1: c = {8'd84,  8'd11,  8'd40};
          4'd2: c = {8'd110, 8'd21,  8'd101};
          4'd3: c = {8'd99,  8'd42,  8'd159};
          4'd4: c = {8'd66,  8'd72,  8'd212};
          4'd5: c = {8'd21,  8'd125, 8'd245};
          4'd6: c = {8'd39,  8'd193, 8'd250};
          4'd7: c = {8'd164, 8'd255, 8'd252};
          default: c = '0;
        endcase
      end
      PAL_KINDL: begin
        case (k)
          4'd0:  c = {8'd0,   8'd0,   8'd0};
          4'd1:  c = {8'd82,  8'd4,   8'd39};
          4'd2:  c = {8'd163, 8'd8,   8'd24};
          4'd3:  c = {8'd142, 8'd69,  8'd7};
          4'd4:  c = {8'd105, 8'd105, 8'd5};
          4'd5:  c = {8'd66,  8'd137, 8'd7};
          4'd6:  c = {8'd8,   8'd168, 8'd15};
          4'd7:  c = {8'd9,   8'd193, 8'd97};
          4'd8:  c = {8'd10,  8'd205, 8'd205};
          4'd9:  c = {8'd163, 8'd210, 8'd251};
          4'd10: c = {8'd223, 8'd232, 8'd253};
          4'd11: c = {8'd255, 8'd255, 8'd255};
          default: c = '0;
        endcase
      end
      PAL_KINDL_X: begin
        case (k)
          4'd0:  c = {8'd0,   8'd0,   8'd0};
          4'd1:  c = {8'd65,  8'd3,   8'd29};
          4'd2:  c = {8'd119, 8'd6,   8'd8};
          4'd3:  c = {8'd87,  8'd49,  8'd4};
          4'd4:  c = {8'd61,  8'd72,  8'd3};
          4'd5:  c = {8'd26,  8'd92,  8'd4};
          4'd6:  c = {8'd5,   8'd110, 8'd22};
          4'd7:  c = {8'd6,   8'd121, 8'd88};
          4'd8:  c = {8'd8,   8'd120, 8'd165};
          4'd9:  c = {8'd58,  8'd98,  8'd246};
          4'd10: c = {8'd135, 8'd125, 8'd249};
          4'd11: c = {8'd225, 8'd144, 8'd250};
          4'd12: c = {8'd251, 8'd182, 8'd225};
          4'd13: c = {8'd253, 8'd209, 8'd227};
          4'd14: c = {8'd254, 8'd234, 8'd233};
          4'd15: c = {8'd255, 8'd255, 8'd255};
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/pseudocolor_palette_mapper_core.sv -----
// ----------------------------------------------------------------------------
// pseudocolor_palette_mapper_core
// Piecewise linear colour-map lookup with contrast gain.
// ----------------------------------------------------------------------------
// One level per clock when neither an output stall nor a table rebuild holds the
// input; each level passes a table read, a contrast multiply and the output
// register. The colour of every level lives in a 256-entry table RAM. After reset
// and after each write of palette_select or center_shift the table is rebuilt,
// one level at a time (region search, products, 8-step divider, which is skipped
// for a level that no region covers); s_tready stays low until the pass is done.
// contrast_gain applies at once.
module pseudocolor_palette_mapper_core
  import ppm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] level
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  logic [PalW-1:0]          palette_select;
  logic signed [ShiftW-1:0] center_shift;
  logic [GainW-1:0]         contrast_gain;
  logic                     cfg_we, rebuild, table_ok;
  ppm_wr_t                  wr;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_select <= '0;
      center_shift   <= '0;
      contrast_gain  <= GainW'(256);
      rebuild        <= 1'b0;
    end else begin
      rebuild <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PALETTE: begin
            palette_select <= cfg_data[PalW-1:0];
            rebuild        <= 1'b1;
          end
          REG_SHIFT: begin
            center_shift <= cfg_data[ShiftW-1:0];
            rebuild      <= 1'b1;
          end
          REG_GAIN: contrast_gain <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  ppm_table_builder u_build (
    .clk            (clk),
    .rst            (rst),
    .start          (rebuild),
    .palette_select (palette_select),
    .center_shift   (center_shift),
    .wr             (wr),
    .done           (table_ok)
  );

  ppm_color_pipe u_pipe (
    .clk           (clk),
    .rst           (rst),
    .wr            (wr),
    .table_ok      (table_ok && !rebuild),
    .contrast_gain (contrast_gain),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_level      (s_tdata),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_rgb       (m_tdata)
  );

endmodule

// ----- sv/ppm_table_builder.sv -----
// ----------------------------------------------------------------------------
// ppm_table_builder
// Sequencer that fills the colour table one level at a time: region search,
// interpolation products, then an 8-step restoring divider per channel.
// ----------------------------------------------------------------------------
module ppm_table_builder
  import ppm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [PalW-1:0]          palette_select,
  input  logic signed [ShiftW-1:0] center_shift,
  output ppm_wr_t                  wr,
  output logic                     done
);

  localparam logic [2:0] B_INIT = 3'd0;
  localparam logic [2:0] B_SEL  = 3'd1;
  localparam logic [2:0] B_MUL  = 3'd2;
  localparam logic [2:0] B_SUM  = 3'd3;
  localparam logic [2:0] B_DIV  = 3'd4;
  localparam logic [2:0] B_WR   = 3'd5;
  localparam logic [2:0] B_DONE = 3'd6;

  logic [2:0]          state;
  logic [LevelW-1:0]   level;
  logic [LevelW-1:0]   pos [MaxStops];
  logic [4:0]          count;
  logic                hit;
  logic [LevelW-1:0]   j, n;
  rgb_t                ca, cb;
  logic [2*ChanW-1:0]  pa [3];
  logic [2*ChanW-1:0]  pb [3];
  logic [ChanW-1:0]    rem [3];
  logic [ChanW-1:0]    low [3];
  logic [ChanW-1:0]    quo [3];
  logic [2:0]          step;

  logic                hit_next;
  logic [StopIdxW-1:0] k_next;
  logic [LevelW-1:0]   p0_sel, p1_sel;

  always_comb begin
    hit_next = 1'b0;
    k_next   = '0;
    for (int k = 0; k < MaxStops - 1; k++) begin
      if ((5'(k) + 5'd1 < count) && (pos[k+1] > pos[k]) &&
          (level >= pos[k]) && (level <= pos[k+1])) begin
        hit_next = 1'b1;
        k_next   = StopIdxW'(k);
      end
    end
    p0_sel = pos[k_next];
    p1_sel = pos[k_next + 4'd1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_INIT;
      level <= '0;
      step  <= '0;
    end else if (start) begin
      state <= B_INIT;
      level <= '0;
      step  <= '0;
    end else begin
      unique case (state)
        B_INIT: begin
          count <= stop_count(palette_select);
          for (int k = 0; k < MaxStops; k++) begin
            logic signed [ShiftW+1:0] s;
            s = $signed({2'b00, base_pos(palette_select, StopIdxW'(k))}) +
                ShiftW'(center_shift);
            if (k == 0 || 5'(k) + 5'd1 >= stop_count(palette_select)) begin
              pos[k] <= base_pos(palette_select, StopIdxW'(k));
            end else if (s < 0) begin
              pos[k] <= '0;
            end else if (s > (TableSize - 1)) begin
              pos[k] <= LevelW'(TableSize - 1);
            end else begin
              pos[k] <= s[LevelW-1:0];
            end
          end
          state <= B_SEL;
        end
        B_SEL: begin
          hit   <= hit_next;
          j     <= level - p0_sel;
          n     <= p1_sel - p0_sel;
          ca    <= stop_color(palette_select, k_next);
          cb    <= stop_color(palette_select, k_next + 4'd1);
          state <= B_MUL;
        end
        B_MUL: begin
          for (int c = 0; c < 3; c++) begin
            pa[c] <= (n - j) * ca[c*ChanW +: ChanW];
            pb[c] <= j * cb[c*ChanW +: ChanW];
          end
          state <= B_SUM;
        end
        B_SUM: begin
          for (int c = 0; c < 3; c++) begin
            logic [2*ChanW-1:0] sm;
            sm = pa[c] + pb[c];
            rem[c] <= sm[2*ChanW-1:ChanW];
            low[c] <= sm[ChanW-1:0];
          end
          step  <= '0;
          state <= hit ? B_DIV : B_WR;
        end
        B_DIV: begin
          for (int c = 0; c < 3; c++) begin
            logic [ChanW:0] t;
            t = {rem[c], low[c][ChanW-1]};
            if (t >= {1'b0, n}) begin
              rem[c] <= ChanW'(t - {1'b0, n});
              quo[c] <= {quo[c][ChanW-2:0], 1'b1};
            end else begin
              rem[c] <= t[ChanW-1:0];
              quo[c] <= {quo[c][ChanW-2:0], 1'b0};
            end
            low[c] <= {low[c][ChanW-2:0], 1'b0};
          end
          step <= step + 3'd1;
          if (step == 3'd7) state <= B_WR;
        end
        B_WR: begin
          level <= level + 8'd1;
          state <= (level == LevelW'(TableSize - 1)) ? B_DONE : B_SEL;
        end
        B_DONE: state <= B_DONE;
        default: state <= B_INIT;
      endcase
    end
  end

  assign wr.en   = (state == B_WR) && !start;
  assign wr.addr = level;
  assign wr.rgb  = hit ? {quo[2], quo[1], quo[0]} : '0;
  assign done    = (state == B_DONE);

endmodule

// ----- sv/ppm_color_pipe.sv -----
// ----------------------------------------------------------------------------
// ppm_color_pipe
// Stream path: colour table read, contrast multiply, saturate, output register.
// Each stage moves forward when the one after it is empty or moving.
// ----------------------------------------------------------------------------
module ppm_color_pipe
  import ppm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ppm_wr_t             wr,
  input  logic                table_ok,
  input  logic [GainW-1:0]    contrast_gain,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [LevelW-1:0]   in_level,
  output logic                out_valid,
  input  logic                out_ready,
  output rgb_t                out_rgb
);

  rgb_t                  mem [TableSize];
  rgb_t                  rd;
  logic                  v1, v2, v3;
  logic [ChanW+GainW-1:0] prod [3];
  logic                  en1, en2, en3;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1 && table_ok;

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.rgb;
    if (en1) rd <= mem[in_level];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid && in_ready;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int c = 0; c < 3; c++) prod[c] <= rd[c*ChanW +: ChanW] * contrast_gain;
    end
    if (en3) begin
      for (int c = 0; c < 3; c++) begin
        if (prod[c][ChanW+GainW-1:2*ChanW] != '0) out_rgb[c*ChanW +: ChanW] <= '1;
        else out_rgb[c*ChanW +: ChanW] <= prod[c][2*ChanW-1:ChanW];
      end
    end
  end

  assign out_valid = v3;

endmodule

// ----- sv/ppm_checker.sv -----
// ----------------------------------------------------------------------------
// ppm_checker
// Port-level checks of the palette mapper, bound to the top level.
// ----------------------------------------------------------------------------
module ppm_checker
  import ppm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [23:0]        m_tdata,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [CfgIdxW-1:0] cfg_index
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("m_tdata changed under stall");

  a_reset_build: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("item path live right after reset");

  a_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index == REG_PALETTE || cfg_index == REG_SHIFT)
    |=> !s_tready)
    else $error("input taken while table is rebuilt");

endmodule

bind pseudocolor_palette_mapper_core ppm_checker u_ppm_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index)
);
